[hdl/tlnf_pkg.sv]
// Package for the line-numbering text filter.
// Holds shared constants, register indexes, and the command and queue status types.
// No dependencies.
package tlnf_pkg;

    localparam int NUMBER_DIGITS_DEF = 6;
    localparam int QUEUE_DEPTH_DEF   = 4;

    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 2;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_SQUEEZE_BLANK    = 3'd0,
        REG_NUMBER_MODE      = 3'd1,
        REG_SHOW_ENDS        = 3'd2,
        REG_SHOW_TABS        = 3'd3,
        REG_SHOW_NONPRINTING = 3'd4
    } tlnf_reg_idx_t;

    localparam logic [1:0] NUM_MODE_OFF      = 2'd0;
    localparam logic [1:0] NUM_MODE_ALL      = 2'd1;
    localparam logic [1:0] NUM_MODE_NONBLANK = 2'd2;
    localparam logic [1:0] NUM_MODE_RESERVED = 2'd3;

    localparam logic [7:0] CH_TAB      = 8'd9;
    localparam logic [7:0] CH_NEWLINE  = 8'd10;
    localparam logic [7:0] CH_US       = 8'd31;
    localparam logic [7:0] CH_SPACE    = 8'd32;
    localparam logic [7:0] CH_DOLLAR   = 8'd36;
    localparam logic [7:0] CH_ZERO     = 8'd48;
    localparam logic [7:0] CH_QUESTION = 8'd63;
    localparam logic [7:0] CH_I        = 8'd73;
    localparam logic [7:0] CH_CARET    = 8'd94;
    localparam logic [7:0] CH_DEL      = 8'd127;
    localparam logic [7:0] CARET_OFFSET = 8'd64;

    // One classified input byte: whether a line number goes first, and the
    // one or two bytes that show the character itself.
    typedef struct packed {
        logic       do_num;
        logic [7:0] first;
        logic       has_second;
        logic [7:0] second;
    } tlnf_cmd_t;

    typedef struct packed {
        logic full;
        logic empty;
    } tlnf_qstat_t;

endpackage

[hdl/tlnf_in_if.sv]
// Input channel of the text filter: one raw byte per transaction.
// Depends on nothing.
interface tlnf_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    logic       file_start;

    modport source (output valid, output in_byte, output file_start, input ready);
    modport sink   (input valid, input in_byte, input file_start, output ready);
endinterface

[hdl/tlnf_out_if.sv]
// Output channel of the text filter: one formatted byte per transaction.
// Depends on nothing.
interface tlnf_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       last_of_run;

    modport source (output valid, output out_byte, output last_of_run, input ready);
    modport sink   (input valid, input out_byte, input last_of_run, output ready);
endinterface

[hdl/tlnf_front.sv]
// Front end of the text filter: configuration registers, line state and byte classification.
// Depends on tlnf_pkg and tlnf_in_if.
module tlnf_front
    import tlnf_pkg::*;
#(
    parameter int NUMBER_DIGITS = NUMBER_DIGITS_DEF
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     wr_en,
    input  logic [CFG_INDEX_W-1:0]   wr_index,
    input  logic [CFG_DATA_W-1:0]    wr_data,
    tlnf_in_if.sink                  in_ch,
    input  tlnf_qstat_t              qstat,
    output logic                     push,
    output tlnf_cmd_t                cmd,
    output logic [4*NUMBER_DIGITS-1:0] bcd
);

    localparam int CW = 4 * NUMBER_DIGITS;

    logic          squeeze_reg;
    logic [1:0]    mode_reg;
    logic          ends_reg;
    logic          tabs_reg;
    logic          nonprint_reg;
    logic          prev_nl_reg, prev_nl_next;
    logic          prev2_nl_reg, prev2_nl_next;
    logic [CW-1:0] count_reg, count_next;

    logic          eff_prev, eff_prev2;
    logic [CW-1:0] eff_count, count_inc;
    logic          is_nl, drop, do_num, accept, all_nines, carry;
    logic [7:0]    c;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            squeeze_reg  <= 1'b0;
            mode_reg     <= NUM_MODE_OFF;
            ends_reg     <= 1'b0;
            tabs_reg     <= 1'b0;
            nonprint_reg <= 1'b0;
        end
        else if (wr_en)
        begin
            unique case (wr_index)
                REG_SQUEEZE_BLANK:    squeeze_reg  <= wr_data[0];
                REG_NUMBER_MODE:      mode_reg     <= wr_data[1:0];
                REG_SHOW_ENDS:        ends_reg     <= wr_data[0];
                REG_SHOW_TABS:        tabs_reg     <= wr_data[0];
                REG_SHOW_NONPRINTING: nonprint_reg <= wr_data[0];
                default: ;
            endcase
        end
    end

    assign in_ch.ready = !qstat.full;
    assign accept      = in_ch.valid && in_ch.ready;
    assign c           = in_ch.in_byte;
    assign is_nl       = (c == CH_NEWLINE);

    // A new file restarts the line history and the counter before this byte.
    assign eff_prev  = in_ch.file_start ? 1'b1 : prev_nl_reg;
    assign eff_prev2 = in_ch.file_start ? 1'b0 : prev2_nl_reg;
    assign eff_count = in_ch.file_start ? CW'(1) : count_reg;

    assign drop   = squeeze_reg && is_nl && eff_prev && eff_prev2;
    assign do_num = eff_prev && ((mode_reg == NUM_MODE_ALL) ||
                                 ((mode_reg == NUM_MODE_NONBLANK) && !is_nl));

    // Decimal increment that holds at all nines.
    always_comb
    begin
        all_nines = 1'b1;
        carry     = 1'b1;
        count_inc = eff_count;
        for (int i = 0; i < NUMBER_DIGITS; i++)
        begin
            if (eff_count[4*i +: 4] != 4'd9)
                all_nines = 1'b0;
        end
        for (int i = 0; i < NUMBER_DIGITS; i++)
        begin
            if (carry)
            begin
                if (eff_count[4*i +: 4] == 4'd9)
                    count_inc[4*i +: 4] = 4'd0;
                else
                begin
                    count_inc[4*i +: 4] = eff_count[4*i +: 4] + 4'd1;
                    carry = 1'b0;
                end
            end
        end
        if (all_nines)
            count_inc = eff_count;
    end

    always_comb
    begin
        prev_nl_next  = prev_nl_reg;
        prev2_nl_next = prev2_nl_reg;
        count_next    = count_reg;
        if (accept)
        begin
            if (drop)
            begin
                prev_nl_next  = eff_prev;
                prev2_nl_next = eff_prev2;
                count_next    = eff_count;
            end
            else
            begin
                prev_nl_next  = is_nl;
                prev2_nl_next = eff_prev;
                count_next    = do_num ? count_inc : eff_count;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_nl_reg  <= 1'b1;
            prev2_nl_reg <= 1'b0;
            count_reg    <= CW'(1);
        end
        else
        begin
            prev_nl_reg  <= prev_nl_next;
            prev2_nl_reg <= prev2_nl_next;
            count_reg    <= count_next;
        end
    end

    // Character expansion into one or two bytes.
    always_comb
    begin
        cmd.do_num     = do_num;
        cmd.first      = c;
        cmd.has_second = 1'b0;
        cmd.second     = c;
        if (ends_reg && is_nl)
        begin
            cmd.first      = CH_DOLLAR;
            cmd.has_second = 1'b1;
            cmd.second     = CH_NEWLINE;
        end
        else if (tabs_reg && (c == CH_TAB))
        begin
            cmd.first      = CH_CARET;
            cmd.has_second = 1'b1;
            cmd.second     = CH_I;
        end
        else if (nonprint_reg && ((c < CH_TAB) || ((c > CH_NEWLINE) && (c <= CH_US))))
        begin
            cmd.first      = CH_CARET;
            cmd.has_second = 1'b1;
            cmd.second     = c + CARET_OFFSET;
        end
        else if (nonprint_reg && (c == CH_DEL))
        begin
            cmd.first      = CH_CARET;
            cmd.has_second = 1'b1;
            cmd.second     = CH_QUESTION;
        end
    end

    assign bcd  = eff_count;
    assign push = accept && !drop;

endmodule

[hdl/tlnf_queue.sv]
// Small register queue between the front and back ends of the text filter.
// Depends on tlnf_pkg.
module tlnf_queue
    import tlnf_pkg::*;
#(
    parameter int WIDTH = 8,
    parameter int DEPTH = QUEUE_DEPTH_DEF
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] wdata,
    input  logic             pop,
    output logic [WIDTH-1:0] rdata,
    output tlnf_qstat_t      qstat
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int NW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PW-1:0]    wr_ptr_reg, rd_ptr_reg;
    logic [NW-1:0]    count_reg;
    logic             do_push, do_pop;

    assign qstat.full  = (count_reg == NW'(DEPTH));
    assign qstat.empty = (count_reg == '0);
    assign do_push     = push && !qstat.full;
    assign do_pop      = pop && !qstat.empty;
    assign rdata       = mem_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (do_push)
            mem_reg[wr_ptr_reg] <= wdata;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
                wr_ptr_reg <= (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            if (do_pop)
                rd_ptr_reg <= (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            if (do_push && !do_pop)
                count_reg <= count_reg + 1'b1;
            else if (do_pop && !do_push)
                count_reg <= count_reg - 1'b1;
        end
    end

endmodule

[hdl/tlnf_back.sv]
// Back end of the text filter: expands one queued command into output bytes.
// Depends on tlnf_pkg and tlnf_out_if.
module tlnf_back
    import tlnf_pkg::*;
#(
    parameter int NUMBER_DIGITS = NUMBER_DIGITS_DEF
)
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       q_valid,
    input  tlnf_cmd_t                  cmd,
    input  logic [4*NUMBER_DIGITS-1:0] bcd,
    output logic                       pop,
    tlnf_out_if.source                 out_ch
);

    localparam int SW = $clog2(NUMBER_DIGITS + 3);
    localparam int DW = (NUMBER_DIGITS > 1) ? $clog2(NUMBER_DIGITS) : 1;

    logic [SW-1:0] step_reg;
    logic          leading_reg;
    logic          out_valid_reg;
    logic [7:0]    out_byte_reg;
    logic          out_last_reg;

    logic [3:0]    digits [NUMBER_DIGITS];
    logic [DW-1:0] di;
    logic [3:0]    d, dsat;
    logic [SW-1:0] cstep;
    logic          in_num, is_tab, blank, last, advance;
    logic [7:0]    byte_val;

    for (genvar g = 0; g < NUMBER_DIGITS; g++)
    begin : g_digits
        assign digits[g] = bcd[4*g +: 4];
    end

    assign in_num = cmd.do_num && (step_reg < SW'(NUMBER_DIGITS));
    assign is_tab = cmd.do_num && (step_reg == SW'(NUMBER_DIGITS));
    assign cstep  = cmd.do_num ? (step_reg - SW'(NUMBER_DIGITS + 1)) : step_reg;
    assign di     = DW'(SW'(NUMBER_DIGITS - 1) - step_reg);
    assign d      = digits[di];
    assign dsat   = (d > 4'd9) ? 4'd9 : d;
    assign blank  = leading_reg && (d == 4'd0) && (di != '0);

    always_comb
    begin
        if (in_num)
            byte_val = blank ? CH_SPACE : (CH_ZERO + {4'd0, dsat});
        else if (is_tab)
            byte_val = CH_TAB;
        else if (cstep == '0)
            byte_val = cmd.first;
        else
            byte_val = cmd.second;
    end

    assign last    = !in_num && !is_tab && (cstep == SW'(cmd.has_second));
    assign advance = q_valid && (!out_valid_reg || out_ch.ready);
    assign pop     = advance && last;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg      <= '0;
            leading_reg   <= 1'b1;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (advance)
            begin
                out_valid_reg <= 1'b1;
                if (last)
                begin
                    step_reg    <= '0;
                    leading_reg <= 1'b1;
                end
                else
                begin
                    step_reg <= step_reg + 1'b1;
                    if (in_num && (d != 4'd0))
                        leading_reg <= 1'b0;
                end
            end
            else if (out_ch.ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_byte_reg <= byte_val;
            out_last_reg <= last;
        end
    end

    assign out_ch.valid       = out_valid_reg;
    assign out_ch.out_byte    = out_byte_reg;
    assign out_ch.last_of_run = out_last_reg;

endmodule

[hdl/text_line_number_visible_filter_top.sv]
// Top level of the line-numbering, visible-character text filter.
// Depends on tlnf_pkg, tlnf_in_if, tlnf_out_if, tlnf_front, tlnf_queue and tlnf_back.

// This block formats a byte stream the way a cat utility does. Each input
// transaction carries one byte and a file_start flag; file_start clears the
// newline history and sets the line counter back to one before that byte is
// handled. Each input byte produces zero to NUMBER_DIGITS + 3 output
// transactions, and last_of_run marks the final byte of each group. A blank
// line squeezed away produces no output at all. The front end takes one
// input transaction per clock as long as its four-entry command queue has
// room, updates the line state and the decimal counter in that same cycle,
// and queues a command. The back end drains the queue into a registered
// output stage at one byte per clock while the receiver is ready, so an
// input byte that expands to k output bytes holds the back end until all k
// are out, and the input stalls only once the queue has filled. The first
// output byte of a command passes through the queue entry and then the
// output register before it is presented. Configuration registers
// (squeeze_blank, number_mode, show_ends, show_tabs, show_nonprinting at
// indexes 0 to 4) are written through wr_en, wr_index and wr_data; the
// user must write them only while the block is idle, which the block itself
// does not enforce, and they apply from the next input on.
module text_line_number_visible_filter_top
    import tlnf_pkg::*;
#(
    parameter int NUMBER_DIGITS = NUMBER_DIGITS_DEF,
    parameter int QUEUE_DEPTH   = QUEUE_DEPTH_DEF
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   wr_en,
    input  logic [CFG_INDEX_W-1:0] wr_index,
    input  logic [CFG_DATA_W-1:0]  wr_data,
    tlnf_in_if.sink                in_ch,
    tlnf_out_if.source             out_ch
);

    localparam int CW = 4 * NUMBER_DIGITS;
    localparam int QW = $bits(tlnf_cmd_t) + CW;

    tlnf_cmd_t     f_cmd, b_cmd;
    logic [CW-1:0] f_bcd, b_bcd;
    logic          push, pop;
    tlnf_qstat_t   qstat;
    logic [QW-1:0] q_rdata;

    // Front end: configuration, line state, classification.
    tlnf_front #(
        .NUMBER_DIGITS (NUMBER_DIGITS)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (wr_en),
        .wr_index (wr_index),
        .wr_data  (wr_data),
        .in_ch    (in_ch),
        .qstat    (qstat),
        .push     (push),
        .cmd      (f_cmd),
        .bcd      (f_bcd)
    );

    // Command queue: each entry holds the counter snapshot and the character bytes.
    tlnf_queue #(
        .WIDTH (QW),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .wdata ({f_cmd, f_bcd}),
        .pop   (pop),
        .rdata (q_rdata),
        .qstat (qstat)
    );

    assign b_cmd = q_rdata[QW-1:CW];
    assign b_bcd = q_rdata[CW-1:0];

    // Back end: byte-by-byte expansion into the output register.
    tlnf_back #(
        .NUMBER_DIGITS (NUMBER_DIGITS)
    ) u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_valid (!qstat.empty),
        .cmd     (b_cmd),
        .bcd     (b_bcd),
        .pop     (pop),
        .out_ch  (out_ch)
    );

    // The front end never pushes into a full queue.
    assert property (@(posedge clk) disable iff (!rst_n) !(push && qstat.full))
        else $error("command pushed into a full queue");

    // With nothing queued and nothing held, no output byte can appear next cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        (qstat.empty && !out_ch.valid) |=> !out_ch.valid)
        else $error("output appeared without a queued command");

    // The back end releases a queue entry only while it is loading the output stage.
    assert property (@(posedge clk) disable iff (!rst_n)
        pop |=> (out_ch.valid && out_ch.last_of_run))
        else $error("queue entry retired without a final output byte");

endmodule

[dv/text_line_number_visible_filter_checker.sv]
// Checker for the line-numbering text filter: mirrors the register writes, predicts the
// output bytes of each accepted input transaction and compares them with the output channel.
// Depends on tlnf_pkg, tlnf_in_if and tlnf_out_if.
module text_line_number_visible_filter_checker
    import tlnf_pkg::*;
#(
    parameter int NUMBER_DIGITS = NUMBER_DIGITS_DEF
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   wr_en,
    input  logic [CFG_INDEX_W-1:0] wr_index,
    input  logic [CFG_DATA_W-1:0]  wr_data,
    tlnf_in_if                     in_ch,
    tlnf_out_if                    out_ch,
    output int                     fail_count,
    output int                     pending,
    output int                     checked
);

    localparam int CW = 4 * NUMBER_DIGITS;
    localparam logic [CW-1:0] ALL_NINES = {NUMBER_DIGITS{4'h9}};

    typedef struct packed {
        logic [7:0] ch;
        logic       last;
    } out_char_t;

    out_char_t expected_chars[$];
    out_char_t want;

    logic                       squeeze_blank;
    logic [1:0]                 number_mode;
    logic                       show_ends;
    logic                       show_tabs;
    logic                       show_nonprinting;

    logic                       prev_nl;
    logic                       prev_prev_nl;
    logic [CW-1:0]              line_bcd;

    task push_char(input logic [7:0] c);
        expected_chars.push_back('{ch: c, last: 1'b0});
    endtask

    // Right-justified decimal line number with space padding, then a tab.
    task push_line_number;
        int         i;
        logic       leading;
        logic [3:0] d;
        leading = 1'b1;
        for (i = NUMBER_DIGITS - 1; i >= 0; i--)
        begin
            d = line_bcd[4*i +: 4];
            if (d != 4'd0 || i == 0)
                leading = 1'b0;
            push_char(leading ? CH_SPACE : CH_ZERO + 8'(d));
        end
        push_char(CH_TAB);
    endtask

    // BCD increment that sticks at all nines.
    task bump_line_count;
        int   i;
        logic carry;
        carry = (line_bcd != ALL_NINES);
        for (i = 0; i < NUMBER_DIGITS; i++)
        begin
            if (carry)
            begin
                if (line_bcd[4*i +: 4] == 4'd9)
                    line_bcd[4*i +: 4] = 4'd0;
                else
                begin
                    line_bcd[4*i +: 4] = line_bcd[4*i +: 4] + 4'd1;
                    carry = 1'b0;
                end
            end
        end
    endtask

    task push_visible(input logic [7:0] c);
        if (show_ends && c == CH_NEWLINE)
        begin
            push_char(CH_DOLLAR);
            push_char(CH_NEWLINE);
        end
        else if (show_tabs && c == CH_TAB)
        begin
            push_char(CH_CARET);
            push_char(CH_I);
        end
        else if (show_nonprinting && (c < CH_TAB || (c > CH_NEWLINE && c <= CH_US)))
        begin
            push_char(CH_CARET);
            push_char(c + CARET_OFFSET);
        end
        else if (show_nonprinting && c == CH_DEL)
        begin
            push_char(CH_CARET);
            push_char(CH_QUESTION);
        end
        else
            push_char(c);
    endtask

    task predict_output(input logic [7:0] c, input logic file_start);
        logic      is_nl;
        out_char_t tail;
        is_nl = (c == CH_NEWLINE);
        if (file_start)
        begin
            prev_nl      = 1'b1;
            prev_prev_nl = 1'b0;
            line_bcd     = CW'(1);
        end
        // A third newline in a row is dropped outright when squeezing.
        if (!(squeeze_blank && is_nl && prev_nl && prev_prev_nl))
        begin
            if (prev_nl && (number_mode == NUM_MODE_ALL ||
                            (number_mode == NUM_MODE_NONBLANK && !is_nl)))
            begin
                push_line_number();
                bump_line_count();
            end
            push_visible(c);
            prev_prev_nl = prev_nl;
            prev_nl      = is_nl;
            tail = expected_chars.pop_back();
            tail.last = 1'b1;
            expected_chars.push_back(tail);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            squeeze_blank    = 1'b0;
            number_mode      = NUM_MODE_OFF;
            show_ends        = 1'b0;
            show_tabs        = 1'b0;
            show_nonprinting = 1'b0;
            prev_nl          = 1'b1;
            prev_prev_nl     = 1'b0;
            line_bcd         = CW'(1);
            expected_chars.delete();
            pending          = 0;
        end
        else
        begin
            if (wr_en)
            begin
                case (wr_index)
                    REG_SQUEEZE_BLANK:    squeeze_blank    = wr_data[0];
                    REG_NUMBER_MODE:      number_mode      = wr_data[1:0];
                    REG_SHOW_ENDS:        show_ends        = wr_data[0];
                    REG_SHOW_TABS:        show_tabs        = wr_data[0];
                    REG_SHOW_NONPRINTING: show_nonprinting = wr_data[0];
                    default: ;
                endcase
            end

            if (in_ch.valid && in_ch.ready)
                predict_output(in_ch.in_byte, in_ch.file_start);

            if (out_ch.valid && out_ch.ready)
            begin
                if (expected_chars.size() == 0)
                begin
                    $error("out_byte: no result expected, actual %h", out_ch.out_byte);
                    fail_count++;
                end
                else
                begin
                    want = expected_chars.pop_front();
                    if (out_ch.out_byte !== want.ch)
                    begin
                        $error("out_byte: expected %h, actual %h", want.ch, out_ch.out_byte);
                        fail_count++;
                    end
                    if (out_ch.last_of_run !== want.last)
                    begin
                        $error("last_of_run: expected %b, actual %b",
                               want.last, out_ch.last_of_run);
                        fail_count++;
                    end
                    checked++;
                end
            end
            pending = expected_chars.size();
        end
    end

endmodule

[dv/text_line_number_visible_filter_top_tb.sv]
// Testbench top for the line-numbering text filter: clock, reset, register writes and
// randomized byte stimulus with flow control on both channels, plus the final verdict.
// Depends on tlnf_pkg, the channel interfaces, the filter top and the filter checker.
module text_line_number_visible_filter_top_tb;
    import tlnf_pkg::*;

    // The limit sits well above the slowest legal run (every byte expanding to
    // nine output bytes behind a receiver that stalls most of the time), so it
    // only trips on a hang.
    localparam int CYCLE_LIMIT       = 200000;
    // Front end plus command queue plus output register; a squeezed newline
    // causes no output, so this many cycles are allowed after the last byte.
    localparam int SETTLE_CYCLES     = 16;
    localparam int SEGMENTS          = 6;
    localparam int ITEMS_PER_SEGMENT = 70;

    logic                   clk = 1'b0;
    logic                   rst_n;
    logic                   wr_en;
    logic [CFG_INDEX_W-1:0] wr_index;
    logic [CFG_DATA_W-1:0]  wr_data;

    tlnf_in_if  in_ch();
    tlnf_out_if out_ch();

    int fail_count;
    int pending;
    int checked;
    int cycle_count = 0;
    int tx_idle_pct = 18;
    int rx_idle_pct = 73;
    int bytes_sent  = 0;
    int settings    = 0;

    text_line_number_visible_filter_top i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (wr_en),
        .wr_index (wr_index),
        .wr_data  (wr_data),
        .in_ch    (in_ch),
        .out_ch   (out_ch)
    );

    text_line_number_visible_filter_checker i_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .wr_en      (wr_en),
        .wr_index   (wr_index),
        .wr_data    (wr_data),
        .in_ch      (in_ch),
        .out_ch     (out_ch),
        .fail_count (fail_count),
        .pending    (pending),
        .checked    (checked)
    );

    always #10 clk = ~clk;

    // Watchdog: a run that never drains is reported as a failure.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles with %0d results outstanding.",
                     cycle_count, pending);
            $display("FAILED: results differ");
            $finish;
        end
    end

    // The receiver drops ready at random, at the rate the current phase asks.
    always @(posedge clk)
    begin
        if (!rst_n)
            out_ch.ready <= 1'b0;
        else
            out_ch.ready <= ($urandom_range(99) >= rx_idle_pct);
    end

    // Sends one byte. The sender may first hold valid low for a random
    // number of cycles. After the transaction is accepted, valid is left high
    // so that back-to-back bytes never see valid dropped and raised in the
    // same time step.
    task send_byte(input logic [7:0] b, input logic file_start);
        while ($urandom_range(99) < tx_idle_pct)
        begin
            in_ch.valid <= 1'b0;
            @(posedge clk);
        end
        in_ch.valid      <= 1'b1;
        in_ch.in_byte    <= b;
        in_ch.file_start <= file_start;
        @(posedge clk);
        while (!in_ch.ready)
            @(posedge clk);
        bytes_sent++;
    endtask

    // Stops sending and waits until every predicted byte has come out, then
    // lets the pipeline settle, since a squeezed newline leaves nothing to
    // wait for. The checker updates its count at the rising edge, so the
    // count is read at the falling edge.
    task wait_drained;
        in_ch.valid <= 1'b0;
        do
            @(negedge clk);
        while (pending != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task write_reg(input tlnf_reg_idx_t idx, input logic [CFG_DATA_W-1:0] value);
        wr_en    <= 1'b1;
        wr_index <= idx;
        wr_data  <= value;
        @(posedge clk);
    endtask

    // Writes all five registers back to back; only called while idle.
    task write_config(input logic squeeze, input logic [1:0] mode, input logic ends,
                      input logic tabs, input logic nonprinting);
        write_reg(REG_SQUEEZE_BLANK, CFG_DATA_W'(squeeze));
        write_reg(REG_NUMBER_MODE, mode);
        write_reg(REG_SHOW_ENDS, CFG_DATA_W'(ends));
        write_reg(REG_SHOW_TABS, CFG_DATA_W'(tabs));
        write_reg(REG_SHOW_NONPRINTING, CFG_DATA_W'(nonprinting));
        wr_en <= 1'b0;
        settings++;
    endtask

    // Mostly printable text, with a fair share of tabs, control bytes, DEL
    // and bytes with the top bit set. Newlines come from the line structure.
    function automatic logic [7:0] pick_text_byte();
        int         r;
        logic [7:0] c;
        r = $urandom_range(99);
        if (r < 55)
            c = 8'($urandom_range(126, 32));
        else if (r < 65)
            c = CH_TAB;
        else if (r < 75)
        begin
            c = 8'($urandom_range(31));
            if (c == CH_NEWLINE)
                c = 8'd0;
        end
        else if (r < 82)
            c = CH_DEL;
        else
            c = 8'($urandom_range(255, 128));
        return c;
    endfunction

    initial
    begin
        int   seg;
        int   seg_count;
        int   line_len;
        int   k;
        logic fs;

        rst_n            = 1'b0;
        wr_en            = 1'b0;
        wr_index         = REG_SQUEEZE_BLANK;
        wr_data          = '0;
        in_ch.valid      = 1'b0;
        in_ch.in_byte    = 8'd0;
        in_ch.file_start = 1'b0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part. Everything on: numbering of every line, visible
        // ends, tabs and control bytes, and squeezing of blank runs.
        write_config(1'b1, NUM_MODE_ALL, 1'b1, 1'b1, 1'b1);
        send_byte(8'h41, 1'b1);
        send_byte(CH_TAB, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(CH_US, 1'b0);
        send_byte(CH_DEL, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(8'h80, 1'b0);
        send_byte(CH_NEWLINE, 1'b0);
        // A blank line is numbered; the next two newlines are squeezed away.
        send_byte(CH_NEWLINE, 1'b0);
        send_byte(CH_NEWLINE, 1'b0);
        send_byte(CH_NEWLINE, 1'b0);
        send_byte(8'h08, 1'b0);
        send_byte(8'h0B, 1'b0);
        send_byte(CH_SPACE, 1'b0);
        send_byte(8'h7E, 1'b0);
        send_byte(CH_NEWLINE, 1'b0);
        wait_drained();

        // Non-blank numbering with every display option off: blank lines get
        // no number, and tab, control bytes and DEL pass through raw.
        write_config(1'b0, NUM_MODE_NONBLANK, 1'b0, 1'b0, 1'b0);
        send_byte(CH_NEWLINE, 1'b0);
        send_byte(CH_NEWLINE, 1'b0);
        send_byte(CH_TAB, 1'b1);
        send_byte(8'h01, 1'b0);
        send_byte(CH_DEL, 1'b0);
        send_byte(CH_NEWLINE, 1'b0);
        wait_drained();

        // The unused numbering code must act as no numbering; tabs are shown
        // without the control-byte display.
        write_config(1'b1, NUM_MODE_RESERVED, 1'b0, 1'b1, 1'b0);
        send_byte(CH_NEWLINE, 1'b0);
        send_byte(CH_NEWLINE, 1'b0);
        send_byte(CH_TAB, 1'b0);
        wait_drained();

        // Random part: segments of line-shaped text with some raw noise. Each
        // segment starts from an idle block with a fresh register setting, since
        // the sender waits for the output to drain at the end of each segment.
        for (seg = 0; seg < SEGMENTS; seg++)
        begin
            tx_idle_pct = (seg < 2) ? 18 : (seg < 4) ? 73 : 0;
            rx_idle_pct = (seg < 2) ? 73 : (seg < 4) ? 18 : 0;
            case (seg)
                0:       write_config(1'b1, NUM_MODE_NONBLANK, 1'b1, 1'b1, 1'b1);
                2:       write_config(1'b0, NUM_MODE_OFF, 1'b0, 1'b0, 1'b0);
                3:       write_config(1'($urandom_range(1)), NUM_MODE_RESERVED,
                                      1'($urandom_range(1)), 1'($urandom_range(1)),
                                      1'($urandom_range(1)));
                default: write_config(1'($urandom_range(1)), 2'($urandom_range(3)),
                                      1'($urandom_range(1)), 1'($urandom_range(1)),
                                      1'($urandom_range(1)));
            endcase

            seg_count = 0;
            while (seg_count < ITEMS_PER_SEGMENT)
            begin
                if ($urandom_range(9) == 0)
                begin
                    // Noise: any byte, now and then starting a new file.
                    send_byte(8'($urandom_range(255)), ($urandom_range(7) == 0));
                    seg_count++;
                end
                else
                begin
                    fs = ($urandom_range(49) == 0);
                    line_len = ($urandom_range(3) == 0) ? 0 : $urandom_range(7, 1);
                    if (line_len == 0)
                    begin
                        // A run of blank lines, long enough at times to squeeze.
                        line_len = $urandom_range(4, 1);
                        for (k = 0; k < line_len; k++)
                        begin
                            send_byte(CH_NEWLINE, fs);
                            fs = 1'b0;
                        end
                        seg_count += line_len;
                    end
                    else
                    begin
                        for (k = 0; k < line_len; k++)
                        begin
                            send_byte(pick_text_byte(), fs);
                            fs = 1'b0;
                        end
                        send_byte(CH_NEWLINE, 1'b0);
                        seg_count += line_len + 1;
                    end
                end
            end
            wait_drained();
        end

        $display("Sent %0d input bytes under %0d register settings; %0d output bytes compared.",
                 bytes_sent, settings, checked);
        $display("Exercised squeezing, all numbering modes, caret escapes and file restarts.");
        if (fail_count == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule

[files.f]
hdl/tlnf_pkg.sv
hdl/tlnf_in_if.sv
hdl/tlnf_out_if.sv
hdl/tlnf_front.sv
hdl/tlnf_queue.sv
hdl/tlnf_back.sv
hdl/text_line_number_visible_filter_top.sv
dv/text_line_number_visible_filter_checker.sv
dv/text_line_number_visible_filter_top_tb.sv
